[src/apsp_pkg.sv]
// Shared types and constants for the all-pairs shortest path block.
package apsp_pkg;

   localparam int VTX_W       = 3;
   localparam int COST_W      = 16;
   localparam int DIST_W      = 24;
   localparam int CSR_W       = 4;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 2;

   // rsp_tuser bit positions
   localparam int TUSER_NEG_CYCLE   = 0;
   localparam int TUSER_UNREACHABLE = 1;

   // req_tuser codes
   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_COMPUTE = 1'b1;

   localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
   localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW_RD,
      ST_ROW_CHK,
      ST_J_RD,
      ST_J_UPD,
      ST_DIAG_RD,
      ST_DIAG_CHK,
      ST_NEG_OUT,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } apsp_state_type;

   typedef struct packed {
      logic                     take;
      logic signed [DIST_W-1:0] sum;
   } relax_result_type;

endpackage

[src/apsp_ram.sv]
// Generic RAM: one write port, two registered read ports.
module apsp_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[src/apsp_relax.sv]
// Shared relaxation unit: saturating leg sum and compare against current entry.
module apsp_relax (
   input  logic signed [apsp_pkg::DIST_W-1:0] leg_ik,
   input  logic signed [apsp_pkg::DIST_W-1:0] leg_kj,
   input  logic signed [apsp_pkg::DIST_W-1:0] cur_ij,
   input  logic                               kj_unreach,
   input  logic                               ij_unreach,
   output apsp_pkg::relax_result_type         result
);

   logic signed [apsp_pkg::DIST_W:0]   sum_wide;
   logic signed [apsp_pkg::DIST_W-1:0] sum_sat;

   assign sum_wide = {leg_ik[apsp_pkg::DIST_W-1], leg_ik}
                   + {leg_kj[apsp_pkg::DIST_W-1], leg_kj};

   always_comb begin
      if (sum_wide[apsp_pkg::DIST_W] != sum_wide[apsp_pkg::DIST_W-1]) begin
         sum_sat = sum_wide[apsp_pkg::DIST_W] ? apsp_pkg::DIST_MIN : apsp_pkg::DIST_MAX;
      end else begin
         sum_sat = sum_wide[apsp_pkg::DIST_W-1:0];
      end
   end

   assign result.sum  = sum_sat;
   assign result.take = !kj_unreach && (ij_unreach || (sum_sat < cur_ij));

endmodule

[src/all_pairs_shortest_path.sv]
// Top level of the all-pairs shortest path block: sequencer, matrix and result register.
//
// Edge transfers (req_tuser = 0) write one signed weight into the distance matrix;
// edges with an endpoint at or above the vertex count are dropped. A compute transfer
// (req_tuser = 1) runs the k, i, j relaxation through one saturating add/compare unit
// against a two-read-port matrix RAM with registered reads: each (k, i) row reads its
// i->k leg and is skipped if that leg is unreachable, else every column is read and
// relaxed; then each diagonal entry is read for the negative-cycle scan; then each entry
// is read and emitted, holding while the output is stalled. Throughout, req_tready and
// csr_ready are low. A negative diagonal yields one result with negative_cycle set and
// tlast; otherwise n*n entries follow in row-major order, the last with tlast. The matrix
// then returns to 0 on the diagonal and unreachable elsewhere, at once, through per-entry
// written flags; no clearing pass is needed. The result register lets a finished result
// wait on rsp_tready while the block takes the next transfer.
module all_pairs_shortest_path #(
   parameter int MAX_VERTICES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration: csr_data = vertex_count
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [apsp_pkg::CSR_W-1:0]          csr_data,
   // req_tdata: src_vertex[2:0], dst_vertex[5:3], edge_cost[21:6], zero pad[23:22]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [apsp_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_tuser: func[0]
   input  logic                                req_tuser,
   // rsp_tdata: row_vertex[2:0], col_vertex[5:3], distance[29:6], zero pad[31:30]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [apsp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // rsp_tuser: negative_cycle[0], unreachable[1]
   output logic [apsp_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   output logic                                rsp_tlast
);

   localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int DW     = apsp_pkg::DIST_W;
   localparam int VW     = apsp_pkg::VTX_W;
   localparam int CW     = apsp_pkg::COST_W;

   // sequencer state and loop counters
   apsp_pkg::apsp_state_type state_ff, state_in;
   logic [IDX_W-1:0]         k_ff, k_in;
   logic [IDX_W-1:0]         i_ff, i_in;
   logic [IDX_W-1:0]         j_ff, j_in;
   logic signed [DW-1:0]     dik_ff, dik_in;     // current row's i->k leg
   logic [CNT_W-1:0]         nv_ff, nv_in;       // clamped vertex count
   logic [DEPTH-1:0]         written_ff, written_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_neg_ff, rsp_unr_ff, rsp_last_ff;
   logic [VW-1:0]            rsp_row_ff, rsp_col_ff;
   logic signed [DW-1:0]     rsp_dist_ff;

   logic                     out_free, out_load, out_neg;
   logic [IDX_W-1:0]         last_v;

   // request fields
   logic                     req_fire;
   logic [VW-1:0]            req_src, req_dst;
   logic [CW-1:0]            req_cost;
   logic                     edge_ok;

   // matrix RAM
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [DW-1:0]            wr_data;
   logic [ADDR_W-1:0]        addr_a, addr_ij;
   logic [DW-1:0]            ram_a, ram_b;
   logic signed [DW-1:0]     a_dist, b_dist;
   logic                     a_unr, b_unr;

   apsp_pkg::relax_result_type relax;

   // row advance (shared by the skip path and the end of a row)
   logic                     row_wrap;
   logic [IDX_W-1:0]         row_next_i, row_next_k;
   apsp_pkg::apsp_state_type row_next_state;

   assign last_v   = IDX_W'(nv_ff - CNT_W'(1));
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == apsp_pkg::ST_IDLE);
   assign csr_ready  = (state_ff == apsp_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_src    = req_tdata[VW-1:0];
   assign req_dst    = req_tdata[2*VW-1:VW];
   assign req_cost   = req_tdata[2*VW+CW-1:2*VW];
   assign edge_ok    = ({1'b0, req_src} < 4'(nv_ff)) && ({1'b0, req_dst} < 4'(nv_ff));

   // port A follows the phase; port B always reads the i,j entry
   assign addr_ij = {i_ff, j_ff};
   always_comb begin
      unique case (state_ff)
         apsp_pkg::ST_ROW_RD, apsp_pkg::ST_ROW_CHK:   addr_a = {i_ff, k_ff};
         apsp_pkg::ST_J_RD, apsp_pkg::ST_J_UPD:       addr_a = {k_ff, j_ff};
         apsp_pkg::ST_DIAG_RD, apsp_pkg::ST_DIAG_CHK: addr_a = {i_ff, i_ff};
         default:                                     addr_a = addr_ij;
      endcase
   end

   // an entry never written since the last clear reads as its reset value
   assign a_dist = written_ff[addr_a] ? ram_a : '0;
   assign a_unr  = !written_ff[addr_a] && (addr_a[ADDR_W-1:IDX_W] != addr_a[IDX_W-1:0]);
   assign b_dist = written_ff[addr_ij] ? ram_b : '0;
   assign b_unr  = !written_ff[addr_ij] && (i_ff != j_ff);

   apsp_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_matrix (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (addr_a),
      .rd_data_a (ram_a),
      .rd_addr_b (addr_ij),
      .rd_data_b (ram_b)
   );

   apsp_relax u_relax (
      .leg_ik     (dik_ff),
      .leg_kj     (a_dist),
      .cur_ij     (b_dist),
      .kj_unreach (a_unr),
      .ij_unreach (b_unr),
      .result     (relax)
   );

   assign row_wrap       = (i_ff == last_v);
   assign row_next_i     = row_wrap ? '0 : i_ff + IDX_W'(1);
   assign row_next_k     = (row_wrap && (k_ff != last_v)) ? k_ff + IDX_W'(1) :
                           (row_wrap ? '0 : k_ff);
   assign row_next_state = (row_wrap && (k_ff == last_v)) ? apsp_pkg::ST_DIAG_RD :
                           apsp_pkg::ST_ROW_RD;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apsp_pkg::ST_IDLE;
         k_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         nv_ff        <= CNT_W'(MAX_VERTICES);
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         nv_ff        <= nv_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dik_ff <= dik_in;
      if (out_load) begin
         rsp_neg_ff  <= out_neg;
         rsp_row_ff  <= out_neg ? '0 : VW'(i_ff);
         rsp_col_ff  <= out_neg ? '0 : VW'(j_ff);
         rsp_unr_ff  <= out_neg ? 1'b0 : a_unr;
         rsp_dist_ff <= (out_neg || a_unr) ? '0 : a_dist;
         rsp_last_ff <= out_neg || ((i_ff == last_v) && (j_ff == last_v));
      end
   end

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      dik_in     = dik_ff;
      nv_in      = nv_ff;
      written_in = written_ff;
      wr_en      = 1'b0;
      wr_addr    = addr_ij;
      wr_data    = relax.sum;
      out_load   = 1'b0;
      out_neg    = 1'b0;

      unique case (state_ff)
         apsp_pkg::ST_IDLE: begin
            if (csr_valid) begin
               if (csr_data == '0) begin
                  nv_in = CNT_W'(1);
               end else if (csr_data > apsp_pkg::CSR_W'(MAX_VERTICES)) begin
                  nv_in = CNT_W'(MAX_VERTICES);
               end else begin
                  nv_in = CNT_W'(csr_data);
               end
            end
            if (req_fire) begin
               if (req_tuser == apsp_pkg::FUNC_LOAD) begin
                  if (edge_ok) begin
                     wr_en               = 1'b1;
                     wr_addr             = {req_src[IDX_W-1:0], req_dst[IDX_W-1:0]};
                     wr_data             = {{(DW-CW){req_cost[CW-1]}}, req_cost};
                     written_in[wr_addr] = 1'b1;
                  end
               end else begin
                  k_in     = '0;
                  i_in     = '0;
                  j_in     = '0;
                  state_in = apsp_pkg::ST_ROW_RD;
               end
            end
         end
         apsp_pkg::ST_ROW_RD: begin
            state_in = apsp_pkg::ST_ROW_CHK;
         end
         apsp_pkg::ST_ROW_CHK: begin
            if (a_unr) begin
               // no path i->k: whole row is skipped
               i_in     = row_next_i;
               k_in     = row_next_k;
               state_in = row_next_state;
            end else begin
               dik_in   = a_dist;
               j_in     = '0;
               state_in = apsp_pkg::ST_J_RD;
            end
         end
         apsp_pkg::ST_J_RD: begin
            state_in = apsp_pkg::ST_J_UPD;
         end
         apsp_pkg::ST_J_UPD: begin
            if (relax.take) begin
               wr_en               = 1'b1;
               written_in[addr_ij] = 1'b1;
               // j == k rewrites the i->k leg used by the rest of the row
               if (j_ff == k_ff) begin
                  dik_in = relax.sum;
               end
            end
            if (j_ff == last_v) begin
               i_in     = row_next_i;
               k_in     = row_next_k;
               state_in = row_next_state;
            end else begin
               j_in     = j_ff + IDX_W'(1);
               state_in = apsp_pkg::ST_J_RD;
            end
         end
         apsp_pkg::ST_DIAG_RD: begin
            state_in = apsp_pkg::ST_DIAG_CHK;
         end
         apsp_pkg::ST_DIAG_CHK: begin
            if (!a_unr && a_dist[DW-1]) begin
               state_in = apsp_pkg::ST_NEG_OUT;
            end else if (i_ff == last_v) begin
               i_in     = '0;
               j_in     = '0;
               state_in = apsp_pkg::ST_EMIT_RD;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = apsp_pkg::ST_DIAG_RD;
            end
         end
         apsp_pkg::ST_NEG_OUT: begin
            if (out_free) begin
               out_load   = 1'b1;
               out_neg    = 1'b1;
               written_in = '0;
               state_in   = apsp_pkg::ST_IDLE;
            end
         end
         apsp_pkg::ST_EMIT_RD: begin
            state_in = apsp_pkg::ST_EMIT_OUT;
         end
         apsp_pkg::ST_EMIT_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (j_ff == last_v) begin
                  j_in = '0;
                  if (i_ff == last_v) begin
                     written_in = '0;
                     state_in   = apsp_pkg::ST_IDLE;
                  end else begin
                     i_in     = i_ff + IDX_W'(1);
                     state_in = apsp_pkg::ST_EMIT_RD;
                  end
               end else begin
                  j_in     = j_ff + IDX_W'(1);
                  state_in = apsp_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = apsp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(apsp_pkg::RSP_TDATA_W - 2*VW - DW){1'b0}},
                        rsp_dist_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = {rsp_unr_ff, rsp_neg_ff};

`ifndef SYNTHESIS
   // matrix is never written while results are read out
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == apsp_pkg::ST_EMIT_RD || state_ff == apsp_pkg::ST_EMIT_OUT ||
       state_ff == apsp_pkg::ST_NEG_OUT) |-> !wr_en)
      else $error("matrix write during result phase");

   // loop counters stay inside the active vertex range while busy
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != apsp_pkg::ST_IDLE) |->
      (i_ff <= last_v && j_ff <= last_v && k_ff <= last_v))
      else $error("loop counter beyond vertex count");

   // final result of a compute leaves the matrix cleared and the block idle
   assert property (@(posedge clock) disable iff (reset)
      (out_load && (out_neg || (i_ff == last_v && j_ff == last_v))) |=>
      (written_ff == '0 && state_ff == apsp_pkg::ST_IDLE))
      else $error("matrix not restored after compute");

   // a negative-cycle result is alone, marked last, with an all-zero payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[apsp_pkg::TUSER_NEG_CYCLE]) |->
      (rsp_tlast && rsp_tdata == '0 && !rsp_tuser[apsp_pkg::TUSER_UNREACHABLE]))
      else $error("malformed negative-cycle result");
`endif

endmodule

[tb/apsp_checker.sv]
// Channel monitor, shortest-path predictor and result checker for the all-pairs block.
module apsp_checker #(
   parameter int MAX_VERTICES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [apsp_pkg::CSR_W-1:0]       csr_data,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [apsp_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [apsp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [apsp_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                             rsp_tlast,
   output int                               fail_count,
   output int                               pending,
   output int                               results_seen,
   output int                               neg_cycles_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [apsp_pkg::CSR_W-1:0] VCOUNT_AT_RESET = 4'd8;

   typedef struct {
      logic                               neg_cycle;
      logic [apsp_pkg::VTX_W-1:0]         row;
      logic [apsp_pkg::VTX_W-1:0]         col;
      logic                               unreachable;
      logic signed [apsp_pkg::DIST_W-1:0] distance;
      logic                               last;
   } path_entry_type;

   // predicted matrix and register
   logic signed [apsp_pkg::DIST_W-1:0] path_len [MAX_VERTICES][MAX_VERTICES];
   bit                                 no_path  [MAX_VERTICES][MAX_VERTICES];
   logic [apsp_pkg::CSR_W-1:0]         vertex_count;
   path_entry_type                     expected_paths [$];

   function automatic void clear_graph();
      for (int i = 0; i < MAX_VERTICES; i++) begin
         for (int j = 0; j < MAX_VERTICES; j++) begin
            path_len[i][j] = '0;
            no_path[i][j]  = (i != j);
         end
      end
   endfunction

   function automatic int active_vertices();
      if (vertex_count < 1) return 1;
      if (vertex_count > MAX_VERTICES) return MAX_VERTICES;
      return int'(vertex_count);
   endfunction

   function automatic logic signed [apsp_pkg::DIST_W-1:0] sat_sum(
         logic signed [apsp_pkg::DIST_W-1:0] a,
         logic signed [apsp_pkg::DIST_W-1:0] b);
      int s;
      s = int'(a) + int'(b);
      if (s > int'(apsp_pkg::DIST_MAX)) return apsp_pkg::DIST_MAX;
      if (s < int'(apsp_pkg::DIST_MIN)) return apsp_pkg::DIST_MIN;
      return apsp_pkg::DIST_W'(s);
   endfunction

   function automatic void load_edge(logic [apsp_pkg::VTX_W-1:0] src,
                                     logic [apsp_pkg::VTX_W-1:0] dst,
                                     logic [apsp_pkg::COST_W-1:0] cost);
      int n;
      n = active_vertices();
      if (src < n && dst < n) begin
         path_len[src][dst] = apsp_pkg::DIST_W'($signed(cost));
         no_path[src][dst]  = 1'b0;
      end
   endfunction

   // k, i, j relaxation in place, then queue either one negative-cycle report or the matrix
   function automatic void solve_and_queue();
      int                                 n;
      logic signed [apsp_pkg::DIST_W-1:0] s;
      path_entry_type                     e;
      bit                                 neg;
      n   = active_vertices();
      neg = 1'b0;
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < n; i++) begin
            if (no_path[i][k]) continue;
            for (int j = 0; j < n; j++) begin
               if (no_path[k][j]) continue;
               s = sat_sum(path_len[i][k], path_len[k][j]);
               if (no_path[i][j] || s < path_len[i][j]) begin
                  path_len[i][j] = s;
                  no_path[i][j]  = 1'b0;
               end
            end
         end
      end
      for (int i = 0; i < n; i++)
         if (!no_path[i][i] && path_len[i][i] < 0) neg = 1'b1;
      if (neg) begin
         e = '{neg_cycle: 1'b1, row: '0, col: '0, unreachable: 1'b0, distance: '0, last: 1'b1};
         expected_paths.push_back(e);
      end else begin
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               e.neg_cycle   = 1'b0;
               e.row         = apsp_pkg::VTX_W'(i);
               e.col         = apsp_pkg::VTX_W'(j);
               e.unreachable = no_path[i][j];
               e.distance    = no_path[i][j] ? '0 : path_len[i][j];
               e.last        = (i == n - 1) && (j == n - 1);
               expected_paths.push_back(e);
            end
         end
      end
      clear_graph();
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_result();
      path_entry_type want;
      results_seen++;
      if (rsp_tuser[apsp_pkg::TUSER_NEG_CYCLE]) neg_cycles_seen++;
      if (expected_paths.size() == 0) begin
         $error("unexpected result transfer: row %0d col %0d", rsp_tdata[2:0], rsp_tdata[5:3]);
         fail_count++;
         return;
      end
      want = expected_paths.pop_front();
      compare_field("negative_cycle", want.neg_cycle, rsp_tuser[apsp_pkg::TUSER_NEG_CYCLE]);
      compare_field("row_vertex", want.row, rsp_tdata[2:0]);
      compare_field("col_vertex", want.col, rsp_tdata[5:3]);
      compare_field("unreachable", want.unreachable, rsp_tuser[apsp_pkg::TUSER_UNREACHABLE]);
      compare_field("distance", int'(want.distance), int'($signed(rsp_tdata[29:6])));
      compare_field("last", want.last, rsp_tlast);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_graph();
         vertex_count = VCOUNT_AT_RESET;
         expected_paths.delete();
         fail_count      = 0;
         results_seen    = 0;
         neg_cycles_seen = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_valid && csr_ready) vertex_count = csr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser == apsp_pkg::FUNC_COMPUTE) solve_and_queue();
            else load_edge(req_tdata[2:0], req_tdata[5:3], req_tdata[21:6]);
         end
      end
      pending = expected_paths.size();
   end

endmodule

[tb/all_pairs_shortest_path_tb.sv]
// Testbench top: stimulus, reset, flow control and verdict for the all-pairs shortest path block.
module all_pairs_shortest_path_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_VERTICES  = 8;
   localparam int ITEM_TARGET   = 250;  // about 260 transfers in all with the last graph
   localparam int SETTLE_CYCLES = 16;
   localparam int IDLE_PCT      = 23;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [apsp_pkg::CSR_W-1:0]       csr_data;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [apsp_pkg::REQ_TDATA_W-1:0] req_tdata;   // src_vertex, dst_vertex, edge_cost, zero pad
   logic                             req_tuser;   // func
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [apsp_pkg::RSP_TDATA_W-1:0] rsp_tdata;   // row_vertex, col_vertex, distance, zero pad
   logic [apsp_pkg::RSP_TUSER_W-1:0] rsp_tuser;   // negative_cycle, unreachable
   logic                             rsp_tlast;

   int fail_count, pending, results_seen, neg_cycles_seen;
   int edges_sent, computes_sent, items_sent;
   int active_n;        // vertex count as the block applies it, for picking endpoints
   bit steady;          // no idling on either side while set

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   all_pairs_shortest_path #(.MAX_VERTICES(NUM_VERTICES)) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   apsp_checker #(.MAX_VERTICES(NUM_VERTICES)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_seen    (results_seen),
      .neg_cycles_seen (neg_cycles_seen)
   );

   // Receiver back-pressure: random stalls land on every phase of the emission.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // One transfer on the request channel. valid stays high into the next call when no gap
   // is taken, so it is never dropped and raised in the same step.
   task automatic send_req(input logic fn, input int src, input int dst,
                           input logic [apsp_pkg::COST_W-1:0] cost);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            req_tdata  <= apsp_pkg::REQ_TDATA_W'($urandom);   // junk while idle
            req_tuser  <= 1'($urandom);
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {2'b00, cost, apsp_pkg::VTX_W'(dst), apsp_pkg::VTX_W'(src)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (fn == apsp_pkg::FUNC_COMPUTE) computes_sent++;
      else edges_sent++;
   endtask

   // Compute transfer; the edge fields are don't-care, so fill them with noise.
   task automatic compute_paths();
      send_req(apsp_pkg::FUNC_COMPUTE, $urandom_range(7), $urandom_range(7),
               apsp_pkg::COST_W'($urandom));
   endtask

   // Hold the sender until every predicted result has been taken, then let things settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, only ever issued with the block idle.
   task automatic set_vertex_count(input int value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= apsp_pkg::CSR_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      active_n = (value < 1) ? 1 : (value > NUM_VERTICES) ? NUM_VERTICES : value;
   endtask

   // Edge weight by graph flavor: small positive, any 16-bit value, mostly-forward
   // negatives, or only the extremes.
   function automatic logic [apsp_pkg::COST_W-1:0] pick_cost(int flavor, int src, int dst);
      case (flavor)
         0: return apsp_pkg::COST_W'($urandom_range(200));
         1: return apsp_pkg::COST_W'($urandom_range(65535));
         2: begin
            if (src < dst && $urandom_range(2) == 0) begin
               return apsp_pkg::COST_W'(-$urandom_range(1, 500));
            end
            return apsp_pkg::COST_W'($urandom_range(2000));
         end
         default: begin
            case ($urandom_range(2))
               0: return 16'h7FFF;
               1: return 16'h8000;
               default: return 16'h0000;
            endcase
         end
      endcase
   endfunction

   // Reset, directed cases, then random graphs across several vertex counts.
   initial begin
      int vc_plan [];
      int plan_idx;
      int graph_idx;
      int flavor;
      int edge_total;
      int s;
      int d;

      vc_plan    = '{1, 0, 15, 2, 5, 9, 4, 7, 3, 6, 8};
      reset      <= 1'b1;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= apsp_pkg::FUNC_LOAD;
      steady     = 1'b0;
      active_n   = NUM_VERTICES;
      plan_idx   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty graph at the reset vertex count: zero diagonal, rest unreachable
      compute_paths();

      // extreme weights along a chain, edge overwrites, self-loops kept and replaced
      send_req(apsp_pkg::FUNC_LOAD, 0, 7, 16'h7FFF);
      send_req(apsp_pkg::FUNC_LOAD, 7, 6, 16'h0000);
      send_req(apsp_pkg::FUNC_LOAD, 6, 5, 16'h8000);
      send_req(apsp_pkg::FUNC_LOAD, 1, 2, 16'd100);
      send_req(apsp_pkg::FUNC_LOAD, 1, 2, -16'sd7);
      send_req(apsp_pkg::FUNC_LOAD, 3, 3, 16'd5);
      send_req(apsp_pkg::FUNC_LOAD, 3, 3, 16'h0000);
      send_req(apsp_pkg::FUNC_LOAD, 4, 4, 16'd9);
      compute_paths();

      // two-vertex negative cycle
      send_req(apsp_pkg::FUNC_LOAD, 2, 5, -16'sd3);
      send_req(apsp_pkg::FUNC_LOAD, 5, 2, 16'd2);
      compute_paths();

      // negative self-loop
      send_req(apsp_pkg::FUNC_LOAD, 6, 6, -16'sd1);
      compute_paths();

      // most negative weights both ways: sums grow fast during relaxation
      send_req(apsp_pkg::FUNC_LOAD, 0, 1, 16'h8000);
      send_req(apsp_pkg::FUNC_LOAD, 1, 0, 16'h8000);
      compute_paths();

      // small graph: endpoints at or above the vertex count are dropped
      set_vertex_count(3);
      send_req(apsp_pkg::FUNC_LOAD, 5, 1, 16'd40);
      send_req(apsp_pkg::FUNC_LOAD, 1, 7, 16'd41);
      send_req(apsp_pkg::FUNC_LOAD, 0, 2, 16'd10);
      send_req(apsp_pkg::FUNC_LOAD, 2, 1, -16'sd4);
      compute_paths();

      // random graphs; a config phase every third graph walks the plan, then random values
      graph_idx = 0;
      while (items_sent < ITEM_TARGET) begin
         if (graph_idx % 3 == 2) begin
            if (plan_idx < vc_plan.size()) set_vertex_count(vc_plan[plan_idx++]);
            else set_vertex_count($urandom_range(15));
         end
         // a long stretch with no idling on either side
         steady = (items_sent >= 130 && items_sent < 190);
         flavor     = $urandom_range(3);
         edge_total = $urandom_range(2 * active_n + 2);
         for (int e = 0; e < edge_total; e++) begin
            if ($urandom_range(9) == 0) begin
               s = $urandom_range(7);
               d = $urandom_range(7);
            end else begin
               s = $urandom_range(active_n - 1);
               d = $urandom_range(active_n - 1);
            end
            send_req(apsp_pkg::FUNC_LOAD, s, d, pick_cost(flavor, s, d));
         end
         // now and then leave the edges standing so the next graph builds on them
         if ($urandom_range(11) != 0) compute_paths();
         // occasional extra compute right behind, on the cleared matrix
         if ($urandom_range(15) == 0) compute_paths();
         if ($urandom_range(7) == 0) drain();
         graph_idx++;
      end
      compute_paths();

      drain();
      $display("Covered %0d edge loads and %0d computes over several vertex counts;",
               edges_sent, computes_sent);
      $display("%0d result transfers checked, %0d of them negative-cycle reports.",
               results_seen, neg_cycles_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #8_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[all_pairs_shortest_path.f]
src/apsp_pkg.sv
src/apsp_ram.sv
src/apsp_relax.sv
src/all_pairs_shortest_path.sv
tb/apsp_checker.sv
tb/all_pairs_shortest_path_tb.sv
